/* rtl/bit_packer_exp_golomb_assert.svh */
// Assertion macros used by the bit packer top level.
`ifndef BIT_PACKER_EXP_GOLOMB_ASSERT_SVH
`define BIT_PACKER_EXP_GOLOMB_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPEG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bit packer check failed");

// Next-cycle implication, disabled during reset.
`define BPEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bit packer check failed");

`endif

/* rtl/bpeg_pkg.sv */
`default_nettype none

package bpeg_pkg;

   // Longest field that a plain bit write may carry.
   localparam int MAX_FIELD_BITS = 32;

   // Port widths.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;

   // Left-aligned bit frame handed from front to back, and the back's work word.
   localparam int FRAME_W = 64;
   localparam int WORK_W  = FRAME_W + 8;

   // Queue between front and back.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = CSR_INDEX_W'(1);

   // Input opcodes.
   typedef enum logic [2:0] {
      OP_BITS  = 3'd0,
      OP_ONE   = 3'd1,
      OP_ZEROS = 3'd2,
      OP_UE    = 3'd3,
      OP_SE    = 3'd4,
      OP_PAD   = 3'd5,
      OP_TRAIL = 3'd6
   } op_type;

   // What the back end does with a queued word.
   typedef enum logic [1:0] {
      KIND_BITS  = 2'd0,
      KIND_PAD   = 2'd1,
      KIND_TRAIL = 2'd2
   } kind_type;

   // One queued operation: bits are left-aligned in the frame.
   typedef struct packed {
      kind_type             kind;
      logic [5:0]           nbits;
      logic [FRAME_W-1:0]   bits_l;
   } entry_type;

   // Configuration as seen by the back end.
   typedef struct packed {
      logic                  tally_only;
      logic [CSR_DATA_W-1:0] capacity;
   } cfg_type;

   // Position of the highest set bit of a byte (0 for a zero byte).
   function automatic logic [2:0] msb_index8(input logic [7:0] b);
      logic [2:0] idx;
      idx = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

/* rtl/bpeg_front.sv */
`default_nettype none

module bpeg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bpeg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [2:0]                        req_tuser,
   output logic                              push_valid,
   input  logic                              push_ready,
   output bpeg_pkg::entry_type               push_entry
);
   import bpeg_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_SCAN  = 3'b010,
      F_ALIGN = 3'b100
   } fstate_type;

   fstate_type  state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [5:0]  nbits_ff, nbits_in;
   logic [31:0] data_ff, data_in;
   logic [1:0]  lane_ff, lane_in;

   op_type      op;
   logic [5:0]  cnt;
   logic [31:0] val;
   logic [31:0] sval;
   logic [31:0] neg;
   logic [31:0] ue_x;
   logic [31:0] se_x;
   logic        do_scan;
   logic [7:0]  lane_byte;
   logic        lane_hit;
   logic [6:0]  shift;
   logic [FRAME_W-1:0] aligned;

   // Field unpacking.
   assign op   = op_type'(req_tuser);
   assign cnt  = req_tdata[5:0];
   assign val  = req_tdata[37:6];
   assign sval = req_tdata[69:38];

   // Exp-Golomb operand plus one, saturated so that it fits in 32 bits.
   assign neg  = 32'd0 - sval;
   assign ue_x = (val == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : val + 32'd1;
   always_comb begin
      if (!sval[31] && (sval != 32'd0)) begin
         se_x = {sval[30:0], 1'b0};
      end else if (sval == 32'h8000_0000) begin
         se_x = 32'hFFFF_FFFF;
      end else begin
         se_x = {neg[30:0], 1'b1};
      end
   end

   // Leading-one search, one byte lane per cycle from the top.
   assign lane_byte = data_ff[{lane_ff, 3'b000} +: 8];
   assign lane_hit  = (lane_byte != 8'd0) || (lane_ff == 2'd0);

   // Left-align the field in the frame.
   assign shift   = 7'(FRAME_W) - {1'b0, nbits_ff};
   assign aligned = (kind_ff == KIND_TRAIL) ? {1'b1, {(FRAME_W-1){1'b0}}}
                                            : ({32'd0, data_ff} << shift);

   assign req_tready        = (state_ff == F_IDLE);
   assign push_valid        = (state_ff == F_ALIGN);
   assign push_entry.kind   = kind_ff;
   assign push_entry.nbits  = nbits_ff;
   assign push_entry.bits_l = aligned;

   // Classification and sequencing.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      nbits_in = nbits_ff;
      data_in  = data_ff;
      lane_in  = lane_ff;
      do_scan  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               kind_in  = KIND_BITS;
               nbits_in = 6'd0;
               data_in  = 32'd0;
               lane_in  = 2'd3;
               case (op)
                  OP_BITS: begin
                     nbits_in = (cnt > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : cnt;
                     data_in  = val;
                  end
                  OP_ONE: begin
                     nbits_in = 6'd1;
                     data_in  = {31'd0, val[0]};
                  end
                  OP_ZEROS: begin
                     nbits_in = cnt;
                  end
                  OP_UE: begin
                     data_in = ue_x;
                     do_scan = 1'b1;
                  end
                  OP_SE: begin
                     data_in = se_x;
                     do_scan = 1'b1;
                  end
                  OP_PAD: begin
                     kind_in = KIND_PAD;
                  end
                  OP_TRAIL: begin
                     kind_in = KIND_TRAIL;
                  end
                  default: begin
                     kind_in = KIND_BITS;
                  end
               endcase
               state_in = do_scan ? F_SCAN : F_ALIGN;
            end
         end
         F_SCAN: begin
            if (lane_hit) begin
               // Prefix of L zeros plus L+1 bits of the operand.
               nbits_in = {lane_ff, msb_index8(lane_byte), 1'b1};
               state_in = F_ALIGN;
            end else begin
               lane_in = lane_ff - 2'd1;
            end
         end
         F_ALIGN: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff  <= kind_in;
      nbits_ff <= nbits_in;
      data_ff  <= data_in;
      lane_ff  <= lane_in;
   end

endmodule

`default_nettype wire

/* rtl/bpeg_fifo.sv */
`default_nettype none

module bpeg_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  bpeg_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output bpeg_pkg::entry_type  pop_entry
);
   import bpeg_pkg::*;

   entry_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]    fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (fill_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/bpeg_back.sv */
`default_nettype none

module bpeg_back (
   input  logic                              clock,
   input  logic                              reset,
   input  bpeg_pkg::cfg_type                 cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  bpeg_pkg::entry_type               pop_entry,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bpeg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   output logic [0:0]                        rsp_tuser
);
   import bpeg_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } bstate_type;

   // Stream state.
   bstate_type            state_ff, state_in;
   logic [2:0]            pc_ff, pc_in;
   logic [6:0]            pend_ff, pend_in;
   logic [CSR_DATA_W-1:0] written_ff, written_in;
   logic                  ovf_ff, ovf_in;
   logic [31:0]           total_ff, total_in;

   // Per-item emission state.
   logic [WORK_W-1:0]     work_ff, work_in;
   logic [3:0]            idx_ff, idx_in;
   logic [3:0]            nres_ff, nres_in;
   logic [3:0]            stored_ff, stored_in;
   logic                  status_ff, status_in;

   // Output register.
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   valid_ff, valid_in;
   logic                   last_ff, last_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic [31:0]            out_total_ff, out_total_in;

   logic [6:0]            n_eff;
   logic [6:0]            tbits;
   logic [WORK_W-1:0]     valign;
   logic [3:0]            nbytes;
   logic [CSR_DATA_W-1:0] avail;
   logic                  drop;
   logic [3:0]            stored;
   logic [32:0]           sum;
   logic                  status;
   logic                  slot_free;
   logic                  emit_valid;
   logic                  emit_last;

   assign pop_ready = (state_ff == B_IDLE);

   // Number of bits this word adds; padding depends on the current position.
   always_comb begin
      case (pop_entry.kind)
         KIND_BITS:  n_eff = {1'b0, pop_entry.nbits};
         KIND_PAD:   n_eff = {4'd0, 3'd0 - pc_ff};
         KIND_TRAIL: n_eff = 7'd8 - {4'd0, pc_ff};
         default:    n_eff = 7'd0;
      endcase
   end

   // Pending bits joined with the new field, left-aligned in the work word.
   assign tbits  = {4'd0, pc_ff} + n_eff;
   assign valign = {pend_ff, {(WORK_W-7){1'b0}}} | ({pop_entry.bits_l, 8'd0} >> pc_ff);
   assign nbytes = tbits[6:3];

   // Capacity check for the whole item at once.
   assign avail  = (written_ff < cfg.capacity) ? cfg.capacity - written_ff : '0;
   assign drop   = ({20'd0, nbytes} > avail);
   assign stored = drop ? avail[3:0] : nbytes;
   assign sum    = {1'b0, total_ff} + {26'd0, n_eff};
   assign status = cfg.tally_only || (nbytes == 4'd0);

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign emit_valid = !status_ff && (idx_ff < stored_ff);
   assign emit_last  = (idx_ff == nres_ff - 4'd1);

   // Load one queued word, then hand out its results one per cycle while the output slot is free.
   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      pend_in       = pend_ff;
      written_in    = written_ff;
      ovf_in        = ovf_ff;
      total_in      = total_ff;
      work_in       = work_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      stored_in     = stored_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      byte_in       = byte_ff;
      valid_in      = valid_ff;
      last_in       = last_ff;
      out_ovf_in    = out_ovf_ff;
      out_total_in  = out_total_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               total_in  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               pc_in     = tbits[2:0];
               work_in   = valign;
               idx_in    = 4'd0;
               nres_in   = status ? 4'd1 : nbytes;
               stored_in = status ? 4'd0 : stored;
               status_in = status;
               if (cfg.tally_only) begin
                  pend_in = 7'd0;
               end else begin
                  if (nbytes == 4'd0) begin
                     pend_in = valign[WORK_W-1 -: 7];
                  end
                  written_in = written_ff + {20'd0, stored};
                  if (drop) begin
                     ovf_in = 1'b1;
                  end
               end
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               valid_in      = emit_valid;
               byte_in       = emit_valid ? work_ff[WORK_W-1 -: 8] : 8'd0;
               last_in       = emit_last;
               out_ovf_in    = ovf_ff;
               out_total_in  = total_ff;
               work_in       = work_ff << 8;
               idx_in        = idx_ff + 4'd1;
               if (emit_last) begin
                  if (!status_ff) begin
                     pend_in = work_ff[WORK_W-9 -: 7];
                  end
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         pc_ff         <= '0;
         pend_ff       <= '0;
         written_ff    <= '0;
         ovf_ff        <= 1'b0;
         total_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         pend_ff       <= pend_in;
         written_ff    <= written_in;
         ovf_ff        <= ovf_in;
         total_ff      <= total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      work_ff      <= work_in;
      idx_ff       <= idx_in;
      nres_ff      <= nres_in;
      stored_ff    <= stored_in;
      status_ff    <= status_in;
      byte_ff      <= byte_in;
      valid_ff     <= valid_in;
      last_ff      <= last_in;
      out_ovf_ff   <= out_ovf_in;
      out_total_ff <= out_total_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, out_total_ff, out_ovf_ff, byte_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = valid_ff;

endmodule

`default_nettype wire

/* rtl/bit_packer_exp_golomb.sv */
`default_nettype none

// MSB-first bit packer with unsigned and signed Exp-Golomb coding. Each request
// word is one syntax operation selected by req_tuser; every byte it completes
// comes out as one response word, and an operation that completes no byte (or
// any operation in count-only mode) gives a single status word. The front end
// takes a request, runs the leading-one search for ue and se operands, and
// aligns the field into a two-entry queue. The back end loads a queued word
// and then hands out one response word per cycle while the output slot is
// free, an operation giving 1 to 8 response words; that byte-per-cycle output
// sets the sustained rate, with the front end working ahead through the queue.
// Configuration writes are taken every cycle and should only be issued while
// no request is in flight.
module bit_packer_exp_golomb (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: count[5:0], value[37:6], signed_value[69:38], zero fill.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bpeg_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: opcode[2:0].
   input  logic [2:0]                          req_tuser,
   // tdata: data_byte[7:0], overflow[8], bit_total[40:9], zero fill.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bpeg_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tlast: last response of the operation.
   output logic                                rsp_tlast,
   // tuser: byte_valid[0].
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpeg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpeg_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bpeg_pkg::*;

   logic                  mode_ff, mode_in;
   logic [CSR_DATA_W-1:0] cap_ff, cap_in;
   cfg_type               cfg;

   logic                  f_push_valid;
   logic                  f_push_ready;
   entry_type             f_push_entry;
   logic                  b_pop_valid;
   logic                  b_pop_ready;
   entry_type             b_pop_entry;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_comb begin
      mode_in = mode_ff;
      cap_in  = cap_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:     mode_in = csr_data[0];
            CSR_CAPACITY: cap_in  = csr_data;
            default:      mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cap_ff  <= '1;
      end else begin
         mode_ff <= mode_in;
         cap_ff  <= cap_in;
      end
   end

   assign cfg.tally_only = mode_ff;
   assign cfg.capacity   = cap_ff;

   bpeg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_entry (f_push_entry)
   );

   bpeg_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_entry (f_push_entry),
      .pop_valid  (b_pop_valid),
      .pop_ready  (b_pop_ready),
      .pop_entry  (b_pop_entry)
   );

   bpeg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (b_pop_valid),
      .pop_ready  (b_pop_ready),
      .pop_entry  (b_pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`include "bit_packer_exp_golomb_assert.svh"

   // Once overflow is reported, every later response reports it too.
   `BPEG_ASSERT_NEXT(a_ovf_sticky, clock, reset, rsp_tvalid && rsp_tdata[8], !rsp_tvalid || rsp_tdata[8])
   // A dropped byte or a status word carries a zero byte.
   `BPEG_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[7:0] == 8'd0)
   // The bit total never goes down from one response to the next.
   `BPEG_ASSERT_NEXT(a_total_up, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid || (rsp_tdata[40:9] >= $past(rsp_tdata[40:9])))
   // The front end is not ready in the cycle after it takes a request.
   `BPEG_ASSERT_NEXT(a_front_busy, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import bpeg_pkg::*;

   // Opcode 7 is left unused by the block and must give one status word.
   localparam logic [2:0]            OP_UNUSED     = 3'd7;
   localparam logic [31:0]           UE_TOP        = 32'hFFFF_FFFE;
   localparam logic [CSR_DATA_W-1:0] CAPACITY_MAX  = '1;
   localparam int                    SETTLE_CYCLES = 16;
   localparam int                    HOLD_CYCLES   = 400;
   localparam int                    CYCLE_LIMIT   = 300000;

   // One response word as the block should present it.
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  data_byte;
      logic        last;
      logic        overflow;
      logic [31:0] bit_total;
   } rsp_word_type;

   // Ways the response side can throttle the block.
   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [2:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the packer state and its configuration.
   logic                  cfg_tally_only = 1'b0;
   logic [CSR_DATA_W-1:0] cfg_capacity   = CAPACITY_MAX;
   logic [6:0]            acc_bits       = '0;
   logic [2:0]            acc_cnt        = '0;
   logic [23:0]           bytes_stored   = '0;
   logic                  overflow_seen  = 1'b0;
   logic [31:0]           bits_seen      = '0;

   // Bytes finished by the operation being predicted, and all words still due.
   rsp_word_type item_bytes_q[$];
   rsp_word_type packed_bytes_q[$];

   int           error_count = 0;
   int           cycle_count = 0;
   int           burst_left  = 0;
   bit           gaps_on     = 1'b1;
   int           hold_left   = 0;
   int           style_left  = 0;
   rx_style_type rx_style    = RX_OPEN;

   bit_packer_exp_golomb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Append one bit to the shadow accumulator; a full byte becomes a word.
   function automatic void pack_bit(logic b);
      logic [7:0] acc;
      if (bits_seen != 32'hFFFF_FFFF) begin
         bits_seen++;
      end
      if (cfg_tally_only) begin
         acc_bits = '0;
         acc_cnt  = acc_cnt + 3'd1;
         return;
      end
      acc = {acc_bits, b};
      if (acc_cnt == 3'd7) begin
         if (bytes_stored < cfg_capacity) begin
            bytes_stored++;
            if (item_bytes_q.size() < 8) begin
               item_bytes_q.push_back(rsp_word_type'{1'b1, acc, 1'b0, 1'b0, 32'd0});
            end
         end else begin
            overflow_seen = 1'b1;
            if (item_bytes_q.size() < 8) begin
               item_bytes_q.push_back(rsp_word_type'{1'b0, 8'd0, 1'b0, 1'b0, 32'd0});
            end
         end
         acc_bits = '0;
         acc_cnt  = '0;
      end else begin
         acc_bits = acc[6:0];
         acc_cnt  = acc_cnt + 3'd1;
      end
   endfunction

   // Exp-Golomb code: leading zeros, then code+1 in its natural length.
   function automatic void pack_ue(logic [31:0] code);
      logic [31:0] x;
      int          n;
      int          i;
      if (code > UE_TOP) begin
         code = UE_TOP;
      end
      x = code + 32'd1;
      n = 0;
      while (n < 31 && (x >> (n + 1)) != 0) begin
         n++;
      end
      for (i = 0; i < n; i++) begin
         pack_bit(1'b0);
      end
      for (i = n; i >= 0; i--) begin
         pack_bit(x[i]);
      end
   endfunction

   function automatic void pack_pad();
      while (acc_cnt != 3'd0) begin
         pack_bit(1'b0);
      end
   endfunction

   // Work out every response word that one accepted operation causes.
   function automatic void pack_item(logic [2:0] op, logic [5:0] cnt, logic [31:0] val,
                                     logic [31:0] sval);
      longint       s;
      longint       c;
      int           nb;
      int           i;
      rsp_word_type w;
      item_bytes_q.delete();
      case (op)
         OP_BITS: begin
            nb = (cnt > 6'd32) ? 32 : int'(cnt);
            for (i = nb - 1; i >= 0; i--) begin
               pack_bit(val[i]);
            end
         end
         OP_ONE: begin
            pack_bit(val[0]);
         end
         OP_ZEROS: begin
            for (i = 0; i < int'(cnt); i++) begin
               pack_bit(1'b0);
            end
         end
         OP_UE: begin
            pack_ue(val);
         end
         OP_SE: begin
            s = $signed(sval);
            c = (s > 0) ? 2 * s - 1 : -2 * s;
            if (c > longint'(UE_TOP)) begin
               c = longint'(UE_TOP);
            end
            pack_ue(c[31:0]);
         end
         OP_PAD: begin
            pack_pad();
         end
         OP_TRAIL: begin
            pack_bit(1'b1);
            pack_pad();
         end
         default: begin
         end
      endcase
      if (item_bytes_q.size() == 0) begin
         item_bytes_q.push_back(rsp_word_type'{1'b0, 8'd0, 1'b0, 1'b0, 32'd0});
      end
      foreach (item_bytes_q[k]) begin
         w           = item_bytes_q[k];
         w.last      = (k == item_bytes_q.size() - 1);
         w.overflow  = overflow_seen;
         w.bit_total = bits_seen;
         packed_bytes_q.push_back(w);
      end
   endfunction

   // Offer one operation, wait for it to be taken, then maybe leave a gap.
   task automatic send_word(input logic [2:0] op, input logic [5:0] cnt,
                            input logic [31:0] val, input logic [31:0] sval);
      @(negedge clock);
      req_tuser  <= op;
      req_tdata  <= {2'b00, sval, val, cnt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pack_item(op, cnt, val, sval);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stop offering and let every predicted word come out.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (packed_bytes_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_MODE) begin
         cfg_tally_only = data[0];
      end else if (index == CSR_CAPACITY) begin
         cfg_capacity = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed syntax elements, with operands biased toward short codes.
   task automatic random_item(output logic [2:0] op, output logic [5:0] cnt,
                              output logic [31:0] val, output logic [31:0] sval);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 28) op = OP_BITS;
      else if (pick < 38) op = OP_ONE;
      else if (pick < 48) op = OP_ZEROS;
      else if (pick < 68) op = OP_UE;
      else if (pick < 84) op = OP_SE;
      else if (pick < 90) op = OP_PAD;
      else if (pick < 97) op = OP_TRAIL;
      else op = OP_UNUSED;
      cnt = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, 32));
      case ($urandom_range(0, 3))
         0: val = $urandom_range(0, 40);
         1: val = $urandom_range(0, 70000);
         2: val = $urandom_range(0, 1) ? UE_TOP : 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase
      case ($urandom_range(0, 3))
         0: sval = $urandom_range(0, 80) - 32'd40;
         1: sval = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: sval = $urandom;
      endcase
   endtask

   task automatic send_random(input int n);
      logic [2:0]  op;
      logic [5:0]  cnt;
      logic [31:0] val;
      logic [31:0] sval;
      repeat (n) begin
         random_item(op, cnt, val, sval);
         send_word(op, cnt, val, sval);
      end
   endtask

   // Field extremes, every opcode, saturation and alignment corners.
   task automatic test_directed_ops();
      send_word(OP_BITS, 6'd0, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_BITS, 6'd1, 32'd1, 32'd0);
      send_word(OP_BITS, 6'd32, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_BITS, 6'd63, 32'hA5C3_0F96, 32'hFFFF_FFFF);
      send_word(OP_BITS, 6'd7, 32'd0, 32'd0);
      send_word(OP_ONE, 6'd0, 32'hFFFF_FFFE, 32'd0);
      send_word(OP_ONE, 6'd63, 32'd1, 32'd0);
      send_word(OP_ZEROS, 6'd0, 32'd0, 32'd0);
      send_word(OP_ZEROS, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_UE, 6'd0, 32'd0, 32'd0);
      send_word(OP_UE, 6'd0, 32'd1, 32'd0);
      send_word(OP_UE, 6'd0, UE_TOP, 32'd0);
      send_word(OP_UE, 6'd0, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_SE, 6'd0, 32'd0, 32'd0);
      send_word(OP_SE, 6'd0, 32'd0, 32'd1);
      send_word(OP_SE, 6'd0, 32'd0, 32'hFFFF_FFFF);
      send_word(OP_SE, 6'd0, 32'd0, 32'h7FFF_FFFF);
      send_word(OP_SE, 6'd0, 32'd0, 32'h8000_0001);
      send_word(OP_SE, 6'd0, 32'd0, 32'h8000_0000);
      send_word(OP_ONE, 6'd0, 32'd1, 32'd0);
      send_word(OP_PAD, 6'd0, 32'd0, 32'd0);
      send_word(OP_PAD, 6'd0, 32'd0, 32'd0);
      send_word(OP_TRAIL, 6'd0, 32'd0, 32'd0);
      send_word(OP_BITS, 6'd3, 32'd5, 32'd0);
      send_word(OP_TRAIL, 6'd0, 32'd0, 32'd0);
      send_word(OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Count-only mode: one status word per operation, position kept modulo 8.
   task automatic test_tally_only();
      wait_idle();
      write_reg(CSR_MODE, 24'd1);
      send_word(OP_BITS, 6'd5, 32'd31, 32'd0);
      send_word(OP_PAD, 6'd0, 32'd0, 32'd0);
      send_word(OP_ONE, 6'd0, 32'd1, 32'd0);
      send_word(OP_TRAIL, 6'd0, 32'd0, 32'd0);
      send_word(OP_ZEROS, 6'd63, 32'd0, 32'd0);
      send_word(OP_UE, 6'd0, 32'hFFFF_FFFF, 32'd0);
      send_random(40);
      wait_idle();
      write_reg(CSR_MODE, 24'd0);
      // Leaves a nonzero position with an empty accumulator behind.
      send_word(OP_BITS, 6'd9, 32'h1FF, 32'd0);
      send_word(OP_PAD, 6'd0, 32'd0, 32'd0);
   endtask

   task automatic test_random_stream(input int n);
      send_random(n);
   endtask

   // Long receiver hold-off fills the block, then the receiver drains it.
   task automatic test_backpressure();
      wait_idle();
      gaps_on   = 1'b0;
      hold_left = HOLD_CYCLES;
      send_random(40);
      gaps_on = 1'b1;
      wait_idle();
   endtask

   // Cross the capacity, drop everything at zero capacity, then reopen it.
   task automatic test_capacity_limit();
      wait_idle();
      write_reg(CSR_CAPACITY, bytes_stored + 24'd5);
      send_random(60);
      wait_idle();
      write_reg(CSR_CAPACITY, 24'd0);
      send_random(40);
      wait_idle();
      write_reg(CSR_CAPACITY, CAPACITY_MAX);
      send_random(60);
   endtask

   // Response side throttling, with an occasional long hold-off.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         if (style_left == 0) begin
            rx_style   = rx_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 160);
         end else begin
            style_left--;
         end
         case (rx_style)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= (style_left % 4 == 0);
            default:   rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (packed_bytes_q.size() == 0) begin
            $error("response word with nothing predicted: tdata %0h", rsp_tdata);
            error_count++;
         end else begin
            want = packed_bytes_q.pop_front();
            if (rsp_tuser[0] !== want.byte_valid) begin
               $error("byte_valid: expected %0h, got %0h", want.byte_valid, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0h, got %0h", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[8] !== want.overflow) begin
               $error("overflow: expected %0h, got %0h", want.overflow, rsp_tdata[8]);
               error_count++;
            end
            if (rsp_tdata[40:9] !== want.bit_total) begin
               $error("bit_total: expected %0h, got %0h", want.bit_total, rsp_tdata[40:9]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_tally_only();
      test_random_stream(150);
      test_backpressure();
      test_capacity_limit();

      wait_idle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/bpeg_pkg.sv
rtl/bpeg_front.sv
rtl/bpeg_fifo.sv
rtl/bpeg_back.sv
rtl/bit_packer_exp_golomb.sv
sim/tb_top.sv
